### rtl/cdre_pkg.sv
// ----------------------------------------------------------------------------
// cdre_pkg
// shared types, codes and constants of the cluster delta run encoder
// ----------------------------------------------------------------------------
package cdre_pkg;

    localparam int unsigned RUN_LEN_W     = 63;
    localparam int unsigned QUEUE_DEPTH_D = 4;

    // second stream cluster codes
    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // old image cluster codes
    localparam logic OLD_UNUSED = 1'b0;
    localparam logic OLD_DATA   = 1'b1;

    // tail codes
    localparam logic [1:0] TAIL_NONE    = 2'd0;
    localparam logic [1:0] TAIL_DISCARD = 2'd1;
    localparam logic [1:0] TAIL_KEEP    = 2'd2;
    localparam logic [1:0] TAIL_SPARE   = 2'd3;

    // transaction kinds on the input side
    localparam logic OP_CLUSTER = 1'b0;
    localparam logic OP_END     = 1'b1;

    // mode register values
    localparam logic MODE_DELTA = 1'b0;
    localparam logic MODE_PATCH = 1'b1;

    // record kinds on the output side
    localparam logic [1:0] REC_SKIP       = 2'd0;
    localparam logic [1:0] REC_DROP       = 2'd1;
    localparam logic [1:0] REC_DATA_OTHER = 2'd2;
    localparam logic [1:0] REC_DATA_OLD   = 2'd3;

    typedef logic [RUN_LEN_W-1:0] run_len_t;

    localparam run_len_t COUNT_MAX = {RUN_LEN_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_FLUSH,
        CMD_EXT_SKIP,
        CMD_EXT_DROP,
        CMD_DATA_OTHER,
        CMD_DATA_OLD
    } cmd_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_SKIP,
        RUN_DROP
    } run_kind_t;

    // front to queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    // queue head to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

### rtl/cdre_front.sv
// ----------------------------------------------------------------------------
// cdre_front
// holds the mode register and makes a command of each undiscarded input
// ----------------------------------------------------------------------------
module cdre_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic              old_kind,
    input  logic [1:0]        other_kind,
    input  logic              data_equal,
    input  logic [1:0]        tail,
    input  logic              queue_full,
    output cdre_pkg::cmd_push_t push
);

    logic mode_reg;
    logic mode_next;
    logic other_data;
    logic old_data;
    cdre_pkg::cmd_t cmd;
    logic           keep;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cdre_pkg::MODE_DELTA;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign other_data = (other_kind != cdre_pkg::KIND_SKIP);
    assign old_data   = (old_kind == cdre_pkg::OLD_DATA);

    always_comb
    begin
        keep = 1'b1;
        cmd  = cdre_pkg::CMD_FLUSH;
        if (op == cdre_pkg::OP_END)
        begin
            cmd = cdre_pkg::CMD_FLUSH;
        end
        else if (tail == cdre_pkg::TAIL_DISCARD)
        begin
            keep = 1'b0;
        end
        else if (tail != cdre_pkg::TAIL_NONE)
        begin
            cmd = cdre_pkg::CMD_DATA_OTHER;
        end
        else if (mode_reg == cdre_pkg::MODE_DELTA)
        begin
            if ((old_data == other_data) && (!old_data || data_equal))
            begin
                cmd = cdre_pkg::CMD_EXT_SKIP;
            end
            else if (!other_data)
            begin
                cmd = cdre_pkg::CMD_EXT_DROP;
            end
            else
            begin
                cmd = cdre_pkg::CMD_DATA_OTHER;
            end
        end
        else
        begin
            if ((other_kind == cdre_pkg::KIND_DROP) ||
                (old_kind == cdre_pkg::OLD_UNUSED && other_kind == cdre_pkg::KIND_SKIP))
            begin
                cmd = cdre_pkg::CMD_EXT_SKIP;
            end
            else if (other_kind == cdre_pkg::KIND_SKIP)
            begin
                cmd = cdre_pkg::CMD_DATA_OLD;
            end
            else
            begin
                cmd = cdre_pkg::CMD_DATA_OTHER;
            end
        end
    end

    assign in_ready   = !queue_full;
    assign push.valid = in_valid && in_ready && keep;
    assign push.cmd   = cmd;

endmodule

### rtl/cdre_queue.sv
// ----------------------------------------------------------------------------
// cdre_queue
// small command fifo between the front and the back
// ----------------------------------------------------------------------------
module cdre_queue
#(
    parameter int unsigned DEPTH = cdre_pkg::QUEUE_DEPTH_D
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cdre_pkg::cmd_push_t push,
    input  logic                pop,
    output logic                full,
    output cdre_pkg::cmd_head_t head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cdre_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

endmodule

### rtl/cdre_back.sv
// ----------------------------------------------------------------------------
// cdre_back
// run state, record generation and output register
// ----------------------------------------------------------------------------
module cdre_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  cdre_pkg::cmd_head_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          record_kind,
    output cdre_pkg::run_len_t  run_length,
    output logic                last
);

    cdre_pkg::run_kind_t pending_reg;
    cdre_pkg::run_kind_t pending_next;
    cdre_pkg::run_len_t  count_reg;
    cdre_pkg::run_len_t  count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          out_kind_reg;
    logic [1:0]          out_kind_next;
    cdre_pkg::run_len_t  out_len_reg;
    cdre_pkg::run_len_t  out_len_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic                out_free;
    logic                load;
    logic [1:0]          run_rec;
    cdre_pkg::run_kind_t ext_kind;
    logic                has_run;

    assign out_free = !out_valid_reg || out_ready;
    assign has_run  = (pending_reg != cdre_pkg::RUN_NONE);
    assign run_rec  = (pending_reg == cdre_pkg::RUN_SKIP) ? cdre_pkg::REC_SKIP
                                                          : cdre_pkg::REC_DROP;
    assign ext_kind = (head.cmd == cdre_pkg::CMD_EXT_SKIP) ? cdre_pkg::RUN_SKIP
                                                           : cdre_pkg::RUN_DROP;

    always_comb
    begin
        pop           = 1'b0;
        load          = 1'b0;
        pending_next  = pending_reg;
        count_next    = count_reg;
        out_kind_next = out_kind_reg;
        out_len_next  = out_len_reg;
        out_last_next = out_last_reg;
        if (head.valid && out_free)
        begin
            case (head.cmd)
                cdre_pkg::CMD_FLUSH:
                begin
                    pop           = 1'b1;
                    load          = has_run;
                    out_kind_next = run_rec;
                    out_len_next  = count_reg;
                    out_last_next = 1'b1;
                    pending_next  = cdre_pkg::RUN_NONE;
                    count_next    = '0;
                end
                cdre_pkg::CMD_EXT_SKIP, cdre_pkg::CMD_EXT_DROP:
                begin
                    pop = 1'b1;
                    if (pending_reg == ext_kind)
                    begin
                        if (count_reg != cdre_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        load          = has_run;
                        out_kind_next = run_rec;
                        out_len_next  = count_reg;
                        out_last_next = 1'b1;
                        pending_next  = ext_kind;
                        count_next    = cdre_pkg::run_len_t'(1);
                    end
                end
                cdre_pkg::CMD_DATA_OTHER, cdre_pkg::CMD_DATA_OLD:
                begin
                    load = 1'b1;
                    if (has_run)
                    begin
                        // flush the run first, data record follows next turn
                        out_kind_next = run_rec;
                        out_len_next  = count_reg;
                        out_last_next = 1'b0;
                        pending_next  = cdre_pkg::RUN_NONE;
                        count_next    = '0;
                    end
                    else
                    begin
                        pop           = 1'b1;
                        out_kind_next = (head.cmd == cdre_pkg::CMD_DATA_OLD)
                                        ? cdre_pkg::REC_DATA_OLD
                                        : cdre_pkg::REC_DATA_OTHER;
                        out_len_next  = '0;
                        out_last_next = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= cdre_pkg::RUN_NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= out_kind_next;
            out_len_reg  <= out_len_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign record_kind = out_kind_reg;
    assign run_length  = out_len_reg;
    assign last        = out_last_reg;

endmodule

### rtl/cluster_delta_run_encoder_unit.sv
// ----------------------------------------------------------------------------
// cluster_delta_run_encoder_unit
// folds classified cluster pairs into skip, drop and data command records
// ----------------------------------------------------------------------------
// one input transaction is taken per clock while the command queue has room;
// a transaction that only extends a run or is a discarded tail cluster gives
// no record, one that closes a run and starts another gives one record, and a
// data cluster behind a pending run gives two records, the run then the data.
// the output register is the single write port of the record stream, so
// sustained rate is one record per clock while the output is not stalled;
// input runs ahead of a stalled output by up to QUEUE_DEPTH commands. mode is
// taken at each input transaction, so write it only when the unit is drained.
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module cluster_delta_run_encoder_unit
#(
    parameter int unsigned QUEUE_DEPTH = cdre_pkg::QUEUE_DEPTH_D
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // old_kind, other_kind[1:0], data_equal, tail[1:0]
    input  logic        s_axis_tuser,   // op
    // record stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // run_length[62:0]
    output logic [1:0]  m_axis_tuser,   // record_kind[1:0]
    output logic        m_axis_tlast    // last record of the input transaction
);

    cdre_pkg::cmd_push_t push;
    cdre_pkg::cmd_head_t head;
    logic                queue_full;
    logic                pop;
    cdre_pkg::run_len_t  run_length;

    // front: mode register and per-cluster classification
    cdre_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser),
        .old_kind   (s_axis_tdata[0]),
        .other_kind (s_axis_tdata[2:1]),
        .data_equal (s_axis_tdata[3]),
        .tail       (s_axis_tdata[5:4]),
        .queue_full (queue_full),
        .push       (push)
    );

    // decouples classification from record output
    cdre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    // back: run tracking and record output register
    cdre_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .record_kind (m_axis_tuser),
        .run_length  (run_length),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, run_length};

endmodule

### rtl/cdre_checker.sv
// ----------------------------------------------------------------------------
// cdre_checker
// port level checks of the record stream
// ----------------------------------------------------------------------------
module cdre_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled record stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("record withdrawn while stalled");

    // data records carry no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
    else $error("data record with nonzero length");

    // run records are never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata != 64'd0)
    else $error("empty run record");

    // only a flushed run ahead of a data record is not last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[1])
    else $error("non-last data record");

endmodule

bind cluster_delta_run_encoder_unit cdre_checker u_cdre_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
